// ===== src/gf2_irreducibility_tester_core_macros.svh =====
// Assertion macros for the GF(2) irreducibility tester.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GF2_IRREDUCIBILITY_TESTER_CORE_MACROS_SVH
`define GF2_IRREDUCIBILITY_TESTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define GF2IRR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define GF2IRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GF2IRR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)

`define GF2IRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/gf2irr_pkg.sv =====
// Shared types and constants for the GF(2) irreducibility tester.
// No dependencies; imported by every module of the block.
package gf2irr_pkg;

    // Fixed field widths
    localparam int COEF_W   = 16;
    localparam int FACTOR_W = 16;
    localparam int DEG_W    = 5;

    localparam int              DEFAULT_MAX_DEGREE = 16;
    localparam logic [DEG_W-1:0] DEGREE_RESET      = 5'd8;
    localparam int              FIRST_DIVISOR      = 2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_REDUCE,
        ST_FINISH
    } state_t;

    // Commands from the sequencer to the reduction unit
    typedef struct packed {
        logic start;
        logic step;
    } div_ctrl_t;

    // Status from the reduction unit
    typedef struct packed {
        logic done;
        logic zero;
    } div_stat_t;

endpackage

// ===== src/gf2irr_div_unit.sv =====
// Shared GF(2) long-division unit: one shift-and-XOR step per cycle while ctrl.step is high.
// Depends on gf2irr_pkg and the assertion macro header.
`include "gf2_irreducibility_tester_core_macros.svh"

module gf2irr_div_unit
    import gf2irr_pkg::*;
#(
    parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  div_ctrl_t                     ctrl,
    input  logic [MAX_DEGREE:0]           candidate,
    input  logic [MAX_DEGREE-1:0]         divisor,
    input  logic [$clog2(MAX_DEGREE+1)-1:0] div_top,
    input  logic [$clog2(MAX_DEGREE+1)-1:0] deg_m,
    output div_stat_t                     stat
);

    localparam int CW = MAX_DEGREE + 1;
    localparam int PW = $clog2(CW);

    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] ds_reg, ds_next;
    logic [PW-1:0] pos_reg, pos_next;

    // Load on start, otherwise reduce one leading position per step
    always_comb
    begin
        rem_next = rem_reg;
        ds_next  = ds_reg;
        pos_next = pos_reg;
        if (ctrl.start)
        begin
            rem_next = candidate;
            ds_next  = {1'b0, divisor} << (deg_m - div_top);
            pos_next = deg_m;
        end
        else if (ctrl.step)
        begin
            if (rem_reg[pos_reg])
            begin
                rem_next = rem_reg ^ ds_reg;
            end
            ds_next  = ds_reg >> 1;
            pos_next = pos_reg - PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            ds_reg  <= '0;
            pos_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            ds_reg  <= ds_next;
            pos_reg <= pos_next;
        end
    end

    // Finished once the position drops below the divisor's degree
    assign stat.done = (pos_reg < div_top);
    assign stat.zero = (rem_reg == '0);

    // Checks
    `GF2IRR_ASSERT_SAME(a_step_not_done, clk, rst_n, ctrl.step, !stat.done, "step issued after reduction finished")
    `GF2IRR_ASSERT_SAME(a_step_aligned, clk, rst_n, ctrl.step, ds_reg[pos_reg], "divisor lead term not under position")
    `GF2IRR_ASSERT_NEXT(a_start_aligned, clk, rst_n, ctrl.start, ds_reg[pos_reg] && rem_reg[pos_reg], "start misaligned")

endmodule

// ===== src/gf2irr_seq.sv =====
// Sequencer: walks the trial divisors and drives the shared division unit.
// Depends on gf2irr_pkg.
module gf2irr_seq
    import gf2irr_pkg::*;
#(
    parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  logic [$clog2(MAX_DEGREE+1)-1:0] deg_m,
    input  div_stat_t                       stat,
    input  logic                            out_free,
    output div_ctrl_t                       ctrl,
    output logic [MAX_DEGREE-1:0]           divisor,
    output logic [$clog2(MAX_DEGREE+1)-1:0] div_top,
    output logic                            busy,
    output logic                            res_load,
    output logic [MAX_DEGREE-1:0]           found
);

    localparam int PW = $clog2(MAX_DEGREE + 1);

    state_t                state_reg, state_next;
    logic [MAX_DEGREE-1:0] j_reg, j_next;
    logic [PW-1:0]         top_reg, top_next;
    logic [MAX_DEGREE-1:0] found_reg, found_next;
    logic [MAX_DEGREE-1:0] last_div;
    logic                  at_last;
    logic [MAX_DEGREE-1:0] j_inc;

    // Last divisor is 2^m - 1
    assign last_div = {MAX_DEGREE{1'b1}} >> (PW'(MAX_DEGREE) - deg_m);
    assign at_last  = (j_reg == last_div);
    assign j_inc    = j_reg + MAX_DEGREE'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = (deg_m == PW'(1)) ? ST_FINISH : ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (stat.done)
                begin
                    state_next = (stat.zero || at_last) ? ST_FINISH : ST_START;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        ctrl       = '0;
        res_load   = 1'b0;
        j_next     = j_reg;
        top_next   = top_reg;
        found_next = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    j_next     = MAX_DEGREE'(FIRST_DIVISOR);
                    top_next   = PW'(1);
                    found_next = '0;
                end
            end
            ST_START:
            begin
                ctrl.start = 1'b1;
            end
            ST_REDUCE:
            begin
                if (!stat.done)
                begin
                    ctrl.step = 1'b1;
                end
                else if (stat.zero)
                begin
                    found_next = j_reg;
                end
                else if (!at_last)
                begin
                    j_next = j_inc;
                    // degree grows when the new divisor is a power of two
                    if ((j_reg & j_inc) == '0)
                    begin
                        top_next = top_reg + PW'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                res_load = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            top_reg   <= PW'(1);
            found_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            top_reg   <= top_next;
            found_reg <= found_next;
        end
    end

    assign divisor = j_reg;
    assign div_top = top_reg;
    assign busy    = (state_reg != ST_IDLE);
    assign found   = found_reg;

endmodule

// ===== src/gf2_irreducibility_tester_core.sv =====
// Top level of the GF(2) irreducibility tester (trial division).
// Depends on gf2irr_pkg, gf2irr_seq, gf2irr_div_unit and the macro header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  in       | in_valid / in_stall  | low_coefficients[15:0]
//  out      | out_valid / out_stall| irreducible, first_factor[15:0]
//  config   | cfg_we               | cfg_data[4:0] (degree)
//
// One beat at a time: in_stall is high from acceptance until the result is
// loaded into the output register. Each trial divisor of degree d passes
// through the shared shift-XOR unit as a load, one step per position from
// m down to d, and a check; divisors run from 2 up to 2^m-1 between the
// accept and the result load; degree 1 goes from accept to result load.
// Reset clears the control state and sets degree to 8.
// A stalled output holds its result; a new beat may be taken meanwhile.
`include "gf2_irreducibility_tester_core_macros.svh"

module gf2_irreducibility_tester_core
    import gf2irr_pkg::*;
#(
    parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [DEG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [COEF_W-1:0]   low_coefficients,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                irreducible,
    output logic [FACTOR_W-1:0] first_factor
);

    localparam int CW = MAX_DEGREE + 1;
    localparam int PW = $clog2(CW);

    logic [DEG_W-1:0]           deg_reg;
    logic [PW-1:0]              deg_m;
    logic [CW-1:0]              cand_reg;
    logic [CW-1:0]              cand_next;
    logic [CW+COEF_W-1:0]       coef_wide;
    logic [MAX_DEGREE+FACTOR_W-1:0] found_wide;
    logic                       in_beat;
    logic                       busy;
    logic                       res_load;
    logic                       out_free;
    logic [MAX_DEGREE-1:0]      found;
    logic [MAX_DEGREE-1:0]      divisor;
    logic [PW-1:0]              div_top;
    div_ctrl_t                  ctrl;
    div_stat_t                  stat;
    logic                       out_valid_reg;
    logic                       irr_reg;
    logic [FACTOR_W-1:0]        factor_reg;

    // Degree register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg <= DEGREE_RESET;
        end
        else if (cfg_we)
        begin
            deg_reg <= cfg_data;
        end
    end

    // Clamp degree to 1 .. MAX_DEGREE
    always_comb
    begin
        priority if (deg_reg == '0)
        begin
            deg_m = PW'(1);
        end
        else if (deg_reg > DEG_W'(MAX_DEGREE))
        begin
            deg_m = PW'(MAX_DEGREE);
        end
        else
        begin
            deg_m = PW'(deg_reg);
        end
    end

    // Candidate: implied leading term plus masked low coefficients
    assign coef_wide = {{CW{1'b0}}, low_coefficients};
    assign cand_next = (CW'(1) << deg_m)
                     | (coef_wide[CW-1:0] & ~({CW{1'b1}} << deg_m));

    assign in_beat  = in_valid && !in_stall;
    assign in_stall = busy;

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cand_reg <= cand_next;
        end
    end

    gf2irr_seq #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (in_beat),
        .deg_m    (deg_m),
        .stat     (stat),
        .out_free (out_free),
        .ctrl     (ctrl),
        .divisor  (divisor),
        .div_top  (div_top),
        .busy     (busy),
        .res_load (res_load),
        .found    (found)
    );

    gf2irr_div_unit #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .candidate (cand_reg),
        .divisor   (divisor),
        .div_top   (div_top),
        .deg_m     (deg_m),
        .stat      (stat)
    );

    // Output register
    assign out_free   = !out_valid_reg || !out_stall;
    assign found_wide = {{FACTOR_W{1'b0}}, found};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            irr_reg    <= (found == '0);
            factor_reg <= found_wide[FACTOR_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign irreducible  = irr_reg;
    assign first_factor = factor_reg;

    // Checks
    `GF2IRR_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_beat, in_stall, "not busy after input beat")
    `GF2IRR_ASSERT_NEXT(a_free_after_load, clk, rst_n, res_load, !in_stall && out_valid, "result load did not release input")
    `GF2IRR_ASSERT_SAME(a_irr_no_factor, clk, rst_n, out_valid && irreducible, first_factor == '0, "irreducible with a factor")

endmodule

// ===== sim/tb_gf2irr_factor_check.sv =====
// Checker for the GF(2) irreducibility tester: watches the config, input and result channels.
// Predicts each verdict by trial division and compares; depends on gf2irr_pkg only.
`timescale 1ns / 100ps

module tb_gf2irr_factor_check
    import gf2irr_pkg::*;
#(
    parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [DEG_W-1:0]    cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [COEF_W-1:0]   low_coefficients,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                irreducible,
    input  logic [FACTOR_W-1:0] first_factor,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic                irreducible;
        logic [FACTOR_W-1:0] first_factor;
    } verdict_t;

    verdict_t         open_verdicts[$];
    logic [DEG_W-1:0] degree_q;

    // Trial division by every divisor 2 .. 2^m-1; stops at the first exact one
    function automatic verdict_t trial_divide(input logic [COEF_W-1:0] coef,
                                              input logic [DEG_W-1:0]  deg_reg);
        int          m;
        int          top;
        int unsigned last;
        logic [16:0] poly;
        logic [16:0] rest;
        logic [16:0] div_v;
        verdict_t    v;
        m = int'(deg_reg);
        if (m < 1)
            m = 1;
        if (m > MAX_DEGREE)
            m = MAX_DEGREE;
        poly  = (17'd1 << m) | ({1'b0, coef} & ((17'd1 << m) - 17'd1));
        last  = (32'd1 << m) - 32'd1;
        v.irreducible  = 1'b1;
        v.first_factor = '0;
        for (int unsigned j = FIRST_DIVISOR; j <= last && v.irreducible; j++)
        begin
            div_v = 17'(j);
            top   = $clog2(j + 1) - 1;
            rest  = poly;
            // long division: clear each set bit from the top down
            for (int b = m; b >= top; b--)
            begin
                if (rest[b])
                    rest = rest ^ (div_v << (b - top));
            end
            if (rest == '0)
            begin
                v.irreducible  = 1'b0;
                v.first_factor = j[FACTOR_W-1:0];
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            degree_q   = DEGREE_RESET;
            fail_count = 0;
            open_verdicts.delete();
            pending    = 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.irreducible  = irreducible;
                got.first_factor = first_factor;
                if (open_verdicts.size() == 0)
                begin
                    $error("result beat with no test outstanding");
                    fail_count++;
                end
                else
                begin
                    want = open_verdicts.pop_front();
                    if (got.irreducible !== want.irreducible)
                    begin
                        $error("irreducible: expected %0d, actual %0d",
                               want.irreducible, got.irreducible);
                        fail_count++;
                    end
                    if (got.first_factor !== want.first_factor)
                    begin
                        $error("first_factor: expected 0x%04h, actual 0x%04h",
                               want.first_factor, got.first_factor);
                        fail_count++;
                    end
                end
            end
            // input beat uses the degree in force before this edge
            if (in_valid && !in_stall)
                open_verdicts.insert(open_verdicts.size(),
                                     trial_divide(low_coefficients, degree_q));
            if (cfg_we)
                degree_q = cfg_data;
            pending = open_verdicts.size();
        end
    end

endmodule

// ===== sim/tb_gf2_irreducibility_tester_core.sv =====
// Testbench top for gf2_irreducibility_tester_core: clock, reset, stimulus and verdict.
// Depends on gf2irr_pkg, the core RTL and tb_gf2irr_factor_check.
`timescale 1ns / 100ps

module tb_gf2_irreducibility_tester_core;
    import gf2irr_pkg::*;

    localparam int          MAX_DEG       = DEFAULT_MAX_DEGREE;
    localparam int unsigned CYCLE_LIMIT   = 3000000;
    localparam int          HOLD_AFTER    = 30;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          BATCHES       = 5;
    localparam int          BATCH_ITEMS   = 16;
    localparam int          CHEAP_DEGREE  = 10;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [DEG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [COEF_W-1:0]   low_coefficients = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                irreducible;
    logic [FACTOR_W-1:0] first_factor;

    int                  fail_count;
    int                  pending;
    bit                  quiet = 1'b0;
    logic [DEG_W-1:0]    degree_now = DEGREE_RESET;
    int unsigned         cycle_count = 0;

    always #4 clk = ~clk;

    gf2_irreducibility_tester_core #(
        .MAX_DEGREE       (MAX_DEG)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .low_coefficients (low_coefficients),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .irreducible      (irreducible),
        .first_factor     (first_factor)
    );

    tb_gf2irr_factor_check #(
        .MAX_DEGREE       (MAX_DEG)
    ) i_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .low_coefficients (low_coefficients),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .irreducible      (irreducible),
        .first_factor     (first_factor),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // Offer one polynomial, with an occasional gap first; valid stays high after
    task automatic send_poly(input logic [COEF_W-1:0] coef);
        if (!quiet && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        low_coefficients <= coef;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Degree change only once every verdict is back
    task automatic load_degree(input logic [DEG_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        degree_now = value;
    endtask

    // Random polynomials; above the cheap degrees force x+1 as a factor so that
    // no long irreducible search runs
    task automatic random_batch(input int count);
        logic [COEF_W-1:0] coef;
        int                m;
        for (int n = 0; n < count; n++)
        begin
            coef = COEF_W'($urandom_range(16'hFFFF));
            m = int'(degree_now);
            if (m < 1)
                m = 1;
            if (m > MAX_DEG)
                m = MAX_DEG;
            if (m > CHEAP_DEGREE && ^(32'(coef) & ((32'd1 << m) - 32'd1)) == 1'b0)
                coef[0] = ~coef[0];
            send_poly(coef);
        end
    endtask

    // Result side: random stall, one long hold-off, quiet while asked
    initial
    begin : result_sink
        int  beats_seen;
        bit  hold_done;
        beats_seen = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                beats_seen++;
            if (beats_seen == HOLD_AFTER && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 22);
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** gf2_irreducibility_tester_core: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset degree 8: x^8, upper bits ignored, the AES polynomial
        send_poly(16'h0000);
        send_poly(16'hFFFF);
        send_poly(16'h001B);
        send_poly(16'hFF1B);

        // degree 1 is irreducible whatever the bits
        load_degree(5'd1);
        send_poly(16'h0000);
        send_poly(16'hFFFF);

        // degree 0 behaves as degree 1
        load_degree(5'd0);
        send_poly(16'h0001);
        send_poly(16'h8000);

        // smallest real search
        load_degree(5'd2);
        send_poly(16'h0003);
        send_poly(16'h0001);
        send_poly(16'h0002);

        // largest degree, one full irreducible search
        load_degree(5'd16);
        send_poly(16'hA011);
        send_poly(16'hFFFF);
        send_poly(16'h0000);
        send_poly(16'h0001);

        // degrees above the maximum clamp to it
        load_degree(5'd31);
        send_poly(16'h0001);
        send_poly(16'h7FFE);
        load_degree(5'd17);
        send_poly(16'h1234);

        // random batches, the second one with no idling at all
        for (int b = 0; b < BATCHES; b++)
        begin
            load_degree(DEG_W'($urandom_range(2, MAX_DEG)));
            quiet = (b == 1);
            random_batch(BATCH_ITEMS);
        end
        quiet = 1'b0;

        // drain
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** gf2_irreducibility_tester_core: PASSED **");
        else
            $display("** gf2_irreducibility_tester_core: FAILED **");
        $finish;
    end

endmodule

// ===== gf2_irreducibility_tester_core.f =====
+incdir+src
src/gf2irr_pkg.sv
src/gf2irr_div_unit.sv
src/gf2irr_seq.sv
src/gf2_irreducibility_tester_core.sv
sim/tb_gf2irr_factor_check.sv
sim/tb_gf2_irreducibility_tester_core.sv
